// ----- hw/rtl/cfdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdp_pkg
// Shared widths, codes and controller/datapath interface types for the
// channel frame to digipot block.
// ----------------------------------------------------------------------------
package cfdp_pkg;

   localparam int BYTE_W       = 8;
   localparam int STORE_DEPTH  = 32;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int ACTION_W     = 3;
   localparam int CHAN_W       = 3;
   localparam int POT_W        = 10;
   localparam int CSR_INDEX_W  = 8;
   localparam int SET_W        = 13;
   localparam int SRC_W        = 15;
   localparam int D_W          = BYTE_W + SRC_W;
   localparam int SV_W         = BYTE_W + SET_W;

   localparam int FRAME_BYTES_DEF = 29;
   localparam int CHANNELS_DEF    = 6;
   localparam int POT_STEPS_DEF   = 1024;

   localparam logic [BYTE_W-1:0] SCALE_RESET = 8'd14;
   localparam logic [BYTE_W-1:0] FULL_RESET  = 8'd20;

   localparam logic [BYTE_W-1:0] CMD_RESET    = 8'h3c;
   localparam logic [BYTE_W-1:0] CMD_SELFTEST = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_FEEDBACK = 8'h3a;
   localparam int                DEC_BASE     = 100;
   localparam logic [CHAN_W-1:0] MASK_TOP_BIT = 3'd6;

   localparam int POS_CMD     = 1;
   localparam int POS_MASK    = 2;
   localparam int POS_TEST    = 15;
   localparam int OFF_SET_HI  = 3;
   localparam int OFF_SET_LO  = 4;
   localparam int OFF_SRC_HI  = 16;
   localparam int OFF_SRC_LO  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL  = 8'd1;

   localparam logic [ACTION_W-1:0] ACT_RESET    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SELFTEST = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FEEDBACK = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CH_ON    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CH_OFF   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_ACK      = 3'd5;

   localparam logic [2:0] SEL_B1   = 3'd0;
   localparam logic [2:0] SEL_B2   = 3'd1;
   localparam logic [2:0] SEL_B15  = 3'd2;
   localparam logic [2:0] SEL_SH   = 3'd3;
   localparam logic [2:0] SEL_SL   = 3'd4;
   localparam logic [2:0] SEL_RH   = 3'd5;
   localparam logic [2:0] SEL_RL   = 3'd6;
   localparam logic [2:0] SEL_NONE = 3'd7;

   typedef struct packed {
      logic                wr_byte;
      logic                clr_pos;
      logic                rd_en;
      logic [2:0]          rd_sel;
      logic [2:0]          cap_sel;
      logic                mask_upd;
      logic                ch_clr;
      logic                ch_next;
      logic                sums;
      logic                mul1;
      logic                mul2;
      logic                div_init;
      logic                div_step;
      logic                emit;
      logic [ACTION_W-1:0] emit_action;
      logic                emit_last;
   } cfdp_cmd_type;

   typedef struct packed {
      logic is_reset;
      logic is_selftest;
      logic is_feedback;
      logic ch_changed;
      logic ch_on;
      logic ch_last;
      logic div_last;
   } cfdp_status_type;

endpackage

// ----- hw/rtl/channel_frame_to_digipot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_frame_to_digipot
// Collects command frame bytes and turns each completed frame into reset,
// self-check, feedback, channel on/off and acknowledge results.
// ----------------------------------------------------------------------------
// A byte that does not end a frame is taken while busy stays low.
// The frame-end byte holds busy high while the frame is decoded: it fetches
// the command, mask and test bytes, tests every channel, reads the set and
// source bytes of each channel switched on and computes its wiper code, and
// emits the acknowledge for a channel frame. Decoding time is set by the
// single read port of the frame store and by the bit-serial divider, which
// yields one quotient bit per cycle. Each result appears on the rsp_ ports
// for exactly one cycle with rsp_strobe high; the receiver cannot stall them,
// so it must take every transfer as it comes.
// ----------------------------------------------------------------------------
module channel_frame_to_digipot
   import cfdp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int POT_STEPS   = POT_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [BYTE_W-1:0]      req_byte_value,
   input  logic                   req_frame_end,
   output logic                   rsp_strobe,
   output logic [ACTION_W-1:0]    rsp_action,
   output logic [CHAN_W-1:0]      rsp_channel,
   output logic                   rsp_polarity,
   output logic [POT_W-1:0]       rsp_pot_code,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   cfdp_cmd_type    cmd;
   cfdp_status_type status;
   logic            start_ok;

   assign csr_ready = 1'b1;
   assign start_ok  = start && !busy;

   cfdp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ok),
      .frame_end (req_frame_end),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   cfdp_datapath #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS),
      .POT_STEPS   (POT_STEPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .byte_value   (req_byte_value),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_action   (rsp_action),
      .rsp_channel  (rsp_channel),
      .rsp_polarity (rsp_polarity),
      .rsp_pot_code (rsp_pot_code),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- hw/rtl/cfdp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/cfdp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdp_datapath
// Frame store, channel mask, configuration registers, wiper code arithmetic
// with a bit-serial divider, and the registered result port.
// ----------------------------------------------------------------------------
module cfdp_datapath
   import cfdp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int POT_STEPS   = POT_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfdp_cmd_type           cmd,
   output cfdp_status_type        status,
   input  logic [BYTE_W-1:0]      byte_value,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data,
   output logic                   rsp_strobe,
   output logic [ACTION_W-1:0]    rsp_action,
   output logic [CHAN_W-1:0]      rsp_channel,
   output logic                   rsp_polarity,
   output logic [POT_W-1:0]       rsp_pot_code,
   output logic                   rsp_last
);

   localparam int POS_W   = $clog2(FRAME_BYTES + 1);
   localparam int QB      = $clog2(POT_STEPS + 1);
   localparam int MULT_W  = $clog2(2 * POT_STEPS + 2);
   localparam int NUM_W   = D_W + MULT_W;
   localparam int STEP_W  = $clog2(QB);

   logic [POS_W-1:0]       pos_ff;
   logic [STORE_DEPTH-1:0] valid_ff;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      ch2;
   logic [BYTE_W-1:0]      ram_q;
   logic [BYTE_W-1:0]      rd_byte;
   logic                   wr_en;

   logic [BYTE_W-1:0]      scale_ff;
   logic [BYTE_W-1:0]      full_ff;
   logic [BYTE_W-1:0]      b1_ff;
   logic [BYTE_W-1:0]      b2_ff;
   logic [BYTE_W-1:0]      b15_ff;
   logic [BYTE_W-1:0]      last_mask_ff;
   logic [BYTE_W-1:0]      changed_ff;
   logic [CHAN_W-1:0]      ch_ff;
   logic [CHAN_W-1:0]      mask_bit;

   logic [BYTE_W-1:0]      sh_ff;
   logic [BYTE_W-1:0]      sl_ff;
   logic [BYTE_W-1:0]      rh_ff;
   logic [BYTE_W-1:0]      rl_ff;
   logic [SET_W-1:0]       set_ff;
   logic [SRC_W-1:0]       src_ff;
   logic [D_W-1:0]         d_ff;
   logic [SV_W-1:0]        sv_ff;
   logic [NUM_W-1:0]       pos_num_ff;
   logic [NUM_W-1:0]       neg_num_ff;
   logic                   dzero_ff;
   logic                   under_ff;
   logic [NUM_W-1:0]       rem_ff;
   logic [NUM_W-1:0]       divsh_ff;
   logic [QB-1:0]          q_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   rem_ge;
   logic [QB-1:0]          q_clamped;
   logic [POT_W-1:0]       code;
   logic                   is_on;

   logic                   strobe_ff;
   logic [ACTION_W-1:0]    action_ff;
   logic [CHAN_W-1:0]      channel_ff;
   logic                   polarity_ff;
   logic [POT_W-1:0]       pot_ff;
   logic                   last_ff;

   assign wr_en = cmd.wr_byte && (pos_ff < POS_W'(FRAME_BYTES));
   assign ch2   = ADDR_W'({ch_ff, 1'b0});

   always_comb begin
      case (cmd.rd_sel)
         SEL_B1:  rd_addr = ADDR_W'(POS_CMD);
         SEL_B2:  rd_addr = ADDR_W'(POS_MASK);
         SEL_B15: rd_addr = ADDR_W'(POS_TEST);
         SEL_SH:  rd_addr = ch2 + ADDR_W'(OFF_SET_HI);
         SEL_SL:  rd_addr = ch2 + ADDR_W'(OFF_SET_LO);
         SEL_RH:  rd_addr = ch2 + ADDR_W'(OFF_SRC_HI);
         SEL_RL:  rd_addr = ch2 + ADDR_W'(OFF_SRC_LO);
         default: rd_addr = '0;
      endcase
   end

   cfdp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (byte_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Positions never written since reset read as zero.
   assign rd_byte = rd_valid_ff ? ram_q : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= '0;
      end else begin
         if (wr_en) begin
            pos_ff                       <= pos_ff + POS_W'(1);
            valid_ff[pos_ff[ADDR_W-1:0]] <= 1'b1;
         end
         if (cmd.clr_pos) begin
            pos_ff <= '0;
         end
      end
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         full_ff  <= FULL_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_SCALE) begin
            scale_ff <= csr_data;
         end else if (csr_index == CSR_FULL) begin
            full_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.cap_sel)
         SEL_B1:  b1_ff  <= rd_byte;
         SEL_B2:  b2_ff  <= rd_byte;
         SEL_B15: b15_ff <= rd_byte;
         SEL_SH:  sh_ff  <= rd_byte;
         SEL_SL:  sl_ff  <= rd_byte;
         SEL_RH:  rh_ff  <= rd_byte;
         SEL_RL:  rl_ff  <= rd_byte;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mask_ff <= '0;
      end else if (cmd.mask_upd) begin
         last_mask_ff <= b2_ff;
      end
      if (cmd.mask_upd) begin
         changed_ff <= last_mask_ff ^ b2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
      end else if (cmd.ch_clr) begin
         ch_ff <= '0;
      end else if (cmd.ch_next) begin
         ch_ff <= ch_ff + CHAN_W'(1);
      end
   end

   assign mask_bit = MASK_TOP_BIT - ch_ff;

   assign status.is_reset    = (b1_ff == CMD_RESET);
   assign status.is_selftest = (b15_ff == CMD_SELFTEST);
   assign status.is_feedback = (b1_ff == CMD_FEEDBACK);
   assign status.ch_changed  = changed_ff[mask_bit];
   assign status.ch_on       = b2_ff[mask_bit];
   assign status.ch_last     = (ch_ff == CHAN_W'(CHANNELS - 1));
   assign status.div_last    = (step_ff == '0);

   assign rem_ge = (rem_ff >= divsh_ff);

   always_ff @(posedge clock) begin
      if (cmd.sums) begin
         set_ff <= SET_W'(sh_ff[5:0]) * SET_W'(DEC_BASE) + SET_W'(sl_ff);
         src_ff <= SRC_W'(rh_ff) * SRC_W'(DEC_BASE) + SRC_W'(rl_ff);
      end
      if (cmd.mul1) begin
         d_ff  <= D_W'(full_ff) * D_W'(src_ff);
         sv_ff <= SV_W'(scale_ff) * SV_W'(set_ff);
      end
      if (cmd.mul2) begin
         pos_num_ff <= NUM_W'(d_ff) * NUM_W'(2 * POT_STEPS + 1);
         neg_num_ff <= NUM_W'(sv_ff) * NUM_W'(2 * POT_STEPS);
         dzero_ff   <= (d_ff == '0);
      end
      if (cmd.div_init) begin
         under_ff <= (neg_num_ff > pos_num_ff);
         rem_ff   <= pos_num_ff - neg_num_ff;
         divsh_ff <= NUM_W'(d_ff) << QB;
         q_ff     <= '0;
         step_ff  <= STEP_W'(QB - 1);
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - divsh_ff;
         end
         divsh_ff <= divsh_ff >> 1;
         q_ff     <= {q_ff[QB-2:0], rem_ge};
         step_ff  <= step_ff - STEP_W'(1);
      end
   end

   assign q_clamped = (q_ff > QB'(POT_STEPS - 1)) ? QB'(POT_STEPS - 1) : q_ff;
   assign code      = (dzero_ff || under_ff) ? '0 : POT_W'(q_clamped);
   assign is_on     = (cmd.emit_action == ACT_CH_ON);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         action_ff   <= cmd.emit_action;
         channel_ff  <= (is_on || cmd.emit_action == ACT_CH_OFF) ? ch_ff : '0;
         polarity_ff <= is_on && (sh_ff[7:6] != 2'b00);
         pot_ff      <= is_on ? code : '0;
         last_ff     <= cmd.emit_last;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_action   = action_ff;
   assign rsp_channel  = channel_ff;
   assign rsp_polarity = polarity_ff;
   assign rsp_pot_code = pot_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- hw/rtl/cfdp_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdp_controller
// Sequencer for byte collection, frame decode and the per-channel
// wiper code computation.
// ----------------------------------------------------------------------------
module cfdp_controller
   import cfdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            frame_end,
   input  cfdp_status_type status,
   output cfdp_cmd_type    cmd,
   output logic            busy
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_RD_B1    = 5'd1;
   localparam logic [4:0] S_RD_B2    = 5'd2;
   localparam logic [4:0] S_RD_B15   = 5'd3;
   localparam logic [4:0] S_CAP_B15  = 5'd4;
   localparam logic [4:0] S_DECIDE   = 5'd5;
   localparam logic [4:0] S_CH_TEST  = 5'd6;
   localparam logic [4:0] S_RD_SH    = 5'd7;
   localparam logic [4:0] S_RD_SL    = 5'd8;
   localparam logic [4:0] S_RD_RH    = 5'd9;
   localparam logic [4:0] S_RD_RL    = 5'd10;
   localparam logic [4:0] S_CAP_RL   = 5'd11;
   localparam logic [4:0] S_SUMS     = 5'd12;
   localparam logic [4:0] S_MUL1     = 5'd13;
   localparam logic [4:0] S_MUL2     = 5'd14;
   localparam logic [4:0] S_DIV_INIT = 5'd15;
   localparam logic [4:0] S_DIV      = 5'd16;
   localparam logic [4:0] S_EMIT_ON  = 5'd17;
   localparam logic [4:0] S_ACK      = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.rd_sel  = SEL_NONE;
      cmd.cap_sel = SEL_NONE;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.wr_byte = 1'b1;
               if (frame_end) begin
                  cmd.clr_pos = 1'b1;
                  state_in    = S_RD_B1;
               end
            end
         end
         S_RD_B1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_B1;
            state_in   = S_RD_B2;
         end
         S_RD_B2: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_B2;
            cmd.cap_sel = SEL_B1;
            state_in    = S_RD_B15;
         end
         S_RD_B15: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_B15;
            cmd.cap_sel = SEL_B2;
            state_in    = S_CAP_B15;
         end
         S_CAP_B15: begin
            cmd.cap_sel = SEL_B15;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.mask_upd = 1'b1;
            if (status.is_reset || status.is_selftest || status.is_feedback) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (status.is_reset) begin
                  cmd.emit_action = ACT_RESET;
               end else if (status.is_selftest) begin
                  cmd.emit_action = ACT_SELFTEST;
               end else begin
                  cmd.emit_action = ACT_FEEDBACK;
               end
               state_in = S_IDLE;
            end else begin
               cmd.ch_clr = 1'b1;
               state_in   = S_CH_TEST;
            end
         end
         S_CH_TEST: begin
            if (status.ch_changed && status.ch_on) begin
               state_in = S_RD_SH;
            end else begin
               if (status.ch_changed) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_action = ACT_CH_OFF;
               end
               if (status.ch_last) begin
                  state_in = S_ACK;
               end else begin
                  cmd.ch_next = 1'b1;
               end
            end
         end
         S_RD_SH: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_SH;
            state_in   = S_RD_SL;
         end
         S_RD_SL: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_SL;
            cmd.cap_sel = SEL_SH;
            state_in    = S_RD_RH;
         end
         S_RD_RH: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_RH;
            cmd.cap_sel = SEL_SL;
            state_in    = S_RD_RL;
         end
         S_RD_RL: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_RL;
            cmd.cap_sel = SEL_RH;
            state_in    = S_CAP_RL;
         end
         S_CAP_RL: begin
            cmd.cap_sel = SEL_RL;
            state_in    = S_SUMS;
         end
         S_SUMS: begin
            cmd.sums = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_EMIT_ON;
            end
         end
         S_EMIT_ON: begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_CH_ON;
            if (status.ch_last) begin
               state_in = S_ACK;
            end else begin
               cmd.ch_next = 1'b1;
               state_in    = S_CH_TEST;
            end
         end
         S_ACK: begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_ACK;
            cmd.emit_last   = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- verif/tb_channel_frame_to_digipot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_frame_to_digipot
// Self-checking bench for the frame decoder. A short table of hand-made
// frames runs first. Random frames follow under several coefficient settings
// and sender idling rates. Every accepted byte passes through a shadow
// decoder that queues the results it should cause, and each strobed result
// is compared field by field with the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_channel_frame_to_digipot;
   import cfdp_pkg::*;

   localparam int FRAME_LEN      = FRAME_BYTES_DEF;
   localparam int CHAN_COUNT     = CHANNELS_DEF;
   localparam int POT_STEPS      = POT_STEPS_DEF;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 7;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAN_W-1:0]   channel;
      logic                polarity;
      logic [POT_W-1:0]    pot_code;
      logic                last;
   } frame_result_type;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              fin;
      bit                typed;
      frame_result_type  want;
   } drive_row_type;

   localparam frame_result_type ACK_ONLY      = '{ACT_ACK, 3'd0, 1'b0, 10'd0, 1'b1};
   localparam frame_result_type RESET_ONLY    = '{ACT_RESET, 3'd0, 1'b0, 10'd0, 1'b1};
   localparam frame_result_type FEEDBACK_ONLY = '{ACT_FEEDBACK, 3'd0, 1'b0, 10'd0, 1'b1};
   localparam frame_result_type NO_RESULT     = '0;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [BYTE_W-1:0]      req_byte_value;
   logic                   req_frame_end;
   logic                   rsp_strobe;
   logic [ACTION_W-1:0]    rsp_action;
   logic [CHAN_W-1:0]      rsp_channel;
   logic                   rsp_polarity;
   logic [POT_W-1:0]       rsp_pot_code;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_data;

   logic [BYTE_W-1:0] shadow_bytes [0:STORE_DEPTH-1];
   int                shadow_pos;
   logic [BYTE_W-1:0] shadow_mask;
   logic [BYTE_W-1:0] cur_scale;
   logic [BYTE_W-1:0] cur_full;

   frame_result_type awaited_results [$];
   frame_result_type fresh_results [$];
   int               mismatch_count;
   int               quiet_cycles;
   int               items_sent;
   int               results_due;
   int               idle_pct;

   drive_row_type directed_rows [20] = '{
      '{8'h00, 1'b1, 1'b1, ACK_ONLY},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h3c, 1'b1, 1'b1, RESET_ONLY},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h3a, 1'b1, 1'b1, FEEDBACK_ONLY},
      '{8'hff, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h40, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h7f, 1'b0, 1'b0, NO_RESULT},
      '{8'hff, 1'b0, 1'b0, NO_RESULT},
      '{8'h63, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b1, 1'b0, NO_RESULT},
      '{8'hff, 1'b1, 1'b1, ACK_ONLY}
   };

   logic [BYTE_W-1:0] phase_scale [PHASES] = '{8'd1, 8'd255, 8'd255, 8'd1, 8'd7, 8'd14, 8'd0};
   logic [BYTE_W-1:0] phase_full  [PHASES] = '{8'd255, 8'd1, 8'd255, 8'd1, 8'd0, 8'd20, 8'd0};
   int                phase_idle  [3]      = '{0, 52, 7};

   channel_frame_to_digipot dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_byte_value (req_byte_value),
      .req_frame_end  (req_frame_end),
      .rsp_strobe     (rsp_strobe),
      .rsp_action     (rsp_action),
      .rsp_channel    (rsp_channel),
      .rsp_polarity   (rsp_polarity),
      .rsp_pot_code   (rsp_pot_code),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The wiper code is the rounded fraction of full scale left after the
   // scaled set value, worked out exactly in integers.
   function automatic logic [POT_W-1:0] expected_wiper(input int c);
      longint set_v, src_v, den, num, q;
      set_v = longint'(shadow_bytes[2*c+OFF_SET_HI] & 8'h3f) * DEC_BASE
            + longint'(shadow_bytes[2*c+OFF_SET_LO]);
      src_v = longint'(shadow_bytes[2*c+OFF_SRC_HI]) * DEC_BASE
            + longint'(shadow_bytes[2*c+OFF_SRC_LO]);
      den = longint'(cur_full) * src_v;
      if (den == 0) return '0;
      num = 2 * longint'(POT_STEPS) * (den - set_v * longint'(cur_scale)) + den;
      if (num < 0) return '0;
      q = num / (2 * den);
      if (q > POT_STEPS - 1) q = POT_STEPS - 1;
      return q[POT_W-1:0];
   endfunction

   function automatic void absorb_byte(input logic [BYTE_W-1:0] value, input logic fin);
      logic [BYTE_W-1:0] cmd, mask, changed, chan_bit;
      frame_result_type  r;
      fresh_results.delete();
      if (shadow_pos < FRAME_LEN) begin
         shadow_bytes[shadow_pos] = value;
         shadow_pos++;
      end
      if (!fin) return;
      shadow_pos = 0;
      cmd  = shadow_bytes[POS_CMD];
      mask = shadow_bytes[POS_MASK];
      r    = '0;
      if (cmd == CMD_RESET || shadow_bytes[POS_TEST] == CMD_SELFTEST || cmd == CMD_FEEDBACK) begin
         if (cmd == CMD_RESET) r.action = ACT_RESET;
         else if (shadow_bytes[POS_TEST] == CMD_SELFTEST) r.action = ACT_SELFTEST;
         else r.action = ACT_FEEDBACK;
         r.last = 1'b1;
         shadow_mask = mask;
         fresh_results.push_back(r);
         return;
      end
      changed     = shadow_mask ^ mask;
      shadow_mask = mask;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         chan_bit = 8'h40 >> c;
         if ((changed & chan_bit) != 0) begin
            r = '0;
            r.channel = c[CHAN_W-1:0];
            if ((mask & chan_bit) != 0) begin
               r.action   = ACT_CH_ON;
               r.polarity = (shadow_bytes[2*c+OFF_SET_HI][7:6] != 2'b00);
               r.pot_code = expected_wiper(c);
            end else begin
               r.action = ACT_CH_OFF;
            end
            fresh_results.push_back(r);
         end
      end
      r        = '0;
      r.action = ACT_ACK;
      r.last   = 1'b1;
      fresh_results.push_back(r);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Entered and left at a falling edge; start stays high on return.
   task automatic put_byte(input logic [BYTE_W-1:0] value, input logic fin,
                           input bit typed, input frame_result_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_byte_value <= value;
      req_frame_end  <= fin;
      do @(posedge clock); while (busy);
      absorb_byte(value, fin);
      if (typed) begin
         awaited_results.push_back(want);
         results_due++;
      end else begin
         foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
         results_due += fresh_results.size();
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      logic [BYTE_W-1:0] fb [0:STORE_DEPTH-1];
      int                len, roll;
      foreach (fb[i]) fb[i] = BYTE_W'($urandom);
      roll = $urandom_range(19);
      if (roll == 0) fb[POS_CMD] = CMD_RESET;
      else if (roll == 1) fb[POS_CMD] = CMD_FEEDBACK;
      if ($urandom_range(19) == 0) fb[POS_TEST] = CMD_SELFTEST;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         case ($urandom_range(7))
            0: begin
               fb[2*c+OFF_SET_HI] = fb[2*c+OFF_SET_HI] & 8'hc0;
               fb[2*c+OFF_SET_LO] = 8'h00;
            end
            1: begin
               fb[2*c+OFF_SRC_HI] = 8'h00;
               fb[2*c+OFF_SRC_LO] = 8'h00;
            end
            2: begin
               fb[2*c+OFF_SRC_HI] = 8'h00;
               fb[2*c+OFF_SRC_LO] = BYTE_W'($urandom_range(1, 9));
            end
            default: begin
               fb[2*c+OFF_SET_LO] = BYTE_W'($urandom_range(0, 99));
               fb[2*c+OFF_SRC_LO] = BYTE_W'($urandom_range(0, 99));
            end
         endcase
      end
      roll = $urandom_range(99);
      if (roll < 60) len = FRAME_LEN;
      else if (roll < 72) len = $urandom_range(FRAME_LEN + 1, STORE_DEPTH);
      else len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         put_byte((i < STORE_DEPTH) ? fb[i] : 8'h00, (i == len - 1), 1'b0, NO_RESULT);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCALE) cur_scale = val;
      else if (idx == CSR_FULL) cur_full = val;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch("unexpected result action", rsp_action, -1);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_action !== want.action) flag_mismatch("action", rsp_action, want.action);
            if (rsp_channel !== want.channel)
               flag_mismatch("channel", rsp_channel, want.channel);
            if (rsp_polarity !== want.polarity)
               flag_mismatch("polarity", rsp_polarity, want.polarity);
            if (rsp_pot_code !== want.pot_code)
               flag_mismatch("pot_code", rsp_pot_code, want.pot_code);
            if (rsp_last !== want.last) flag_mismatch("last", rsp_last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_byte_value = '0;
      req_frame_end  = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      quiet_cycles   = 0;
      mismatch_count = 0;
      items_sent     = 0;
      results_due    = 0;
      idle_pct       = 0;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_pos  = 0;
      shadow_mask = '0;
      cur_scale   = SCALE_RESET;
      cur_full    = FULL_RESET;
      phase_scale[PHASES-1] = BYTE_W'($urandom_range(1, 255));
      phase_full[PHASES-1]  = BYTE_W'($urandom_range(1, 255));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         put_byte(directed_rows[i].value, directed_rows[i].fin,
                  directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         int first_item, first_result;
         start <= 1'b0;
         wait_drained();
         write_reg(CSR_SCALE, phase_scale[p]);
         write_reg(CSR_FULL, phase_full[p]);
         csr_valid <= 1'b0;
         idle_pct     = phase_idle[p % 3];
         first_item   = items_sent;
         first_result = results_due;
         while (items_sent - first_item < 26 || results_due - first_result < 3) send_frame();
      end

      start <= 1'b0;
      wait_drained();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
